@@ hdl/owbm_pkg.sv @@
// Shared types and constants for the one-wire bus master.
// Used by every module of the block; depends on nothing.
`default_nettype none

package owbm_pkg;

   // counter width default and duration register width
   localparam int COUNT_WIDTH_DEFAULT = 10;
   localparam int LEN_WIDTH           = 10;

   // configuration port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 10;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RESET_LOW     = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PRESENCE_WAIT = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RESET_RECOVER = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SLOT_LOW      = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WRITE_HOLD    = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_READ_SAMPLE   = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_READ_TAIL     = 3'd6;

   // register reset values
   localparam logic [9:0] RESET_LOW_DEFAULT     = 10'd480;
   localparam logic [7:0] PRESENCE_WAIT_DEFAULT = 8'd60;
   localparam logic [9:0] RESET_RECOVER_DEFAULT = 10'd480;
   localparam logic [5:0] SLOT_LOW_DEFAULT      = 6'd1;
   localparam logic [7:0] WRITE_HOLD_DEFAULT    = 8'd60;
   localparam logic [7:0] READ_SAMPLE_DEFAULT   = 8'd15;
   localparam logic [7:0] READ_TAIL_DEFAULT     = 8'd50;

   // input op codes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_RESET = 2'd1;
   localparam logic [1:0] OP_WRITE = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      ITEM_TICK,
      ITEM_RESET,
      ITEM_WRITE,
      ITEM_READ
   } item_kind_type;

   typedef struct packed {
      item_kind_type kind;
      logic [7:0]    tx_byte;
      logic          line_in;
   } item_type;

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_RST_LOW,
      PH_RST_WAIT,
      PH_RST_RECOVER,
      PH_WR_LOW,
      PH_WR_HOLD,
      PH_RD_LOW,
      PH_RD_WAIT,
      PH_RD_TAIL
   } phase_type;

   // queue to engine handshake
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

endpackage

`default_nettype wire

@@ hdl/owbm_front.sv @@
// Front stage: takes items from the request channel, classifies the op
// and holds the item until the queue has room. Depends on owbm_pkg.
`default_nettype none

module owbm_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_op,
   input  wire logic [7:0]        req_tx_byte,
   input  wire logic              req_line_in,
   input  wire logic              q_ready,
   output logic                   q_push,
   output owbm_pkg::item_type     q_item
);

   logic                   valid_ff, valid_in;
   owbm_pkg::item_type     item_ff, item_in;
   owbm_pkg::item_kind_type kind;
   logic                   accept;

   // op decode
   always_comb begin
      case (req_op)
         owbm_pkg::OP_TICK:  kind = owbm_pkg::ITEM_TICK;
         owbm_pkg::OP_RESET: kind = owbm_pkg::ITEM_RESET;
         owbm_pkg::OP_WRITE: kind = owbm_pkg::ITEM_WRITE;
         default:            kind = owbm_pkg::ITEM_READ;
      endcase
   end

   // stall only while holding an item the queue cannot take
   assign req_stall = valid_ff && !q_ready;
   assign accept    = req_valid && !req_stall;
   assign q_push    = valid_ff && q_ready;
   assign q_item    = item_ff;

   always_comb begin
      item_in.kind    = kind;
      item_in.tx_byte = req_tx_byte;
      item_in.line_in = req_line_in;
      if (accept) begin
         valid_in = 1'b1;
      end else if (q_push) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/owbm_queue.sv @@
// Two-entry item queue between the front stage and the bus engine.
// Depends on owbm_pkg.
`default_nettype none

module owbm_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire owbm_pkg::item_type      push_item,
   output logic                         ready,
   input  wire logic                    pop,
   output owbm_pkg::queue_out_type      head
);

   owbm_pkg::item_type                    entry_ff [owbm_pkg::QUEUE_DEPTH];
   logic [owbm_pkg::QPTR_WIDTH-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [owbm_pkg::QPTR_WIDTH-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [owbm_pkg::QPTR_WIDTH:0]         count_ff, count_in;

   localparam logic [owbm_pkg::QPTR_WIDTH:0] FULL =
      (owbm_pkg::QPTR_WIDTH+1)'(owbm_pkg::QUEUE_DEPTH);
   localparam logic [owbm_pkg::QPTR_WIDTH-1:0] LAST =
      owbm_pkg::QPTR_WIDTH'(owbm_pkg::QUEUE_DEPTH - 1);

   assign ready      = count_ff != FULL;
   assign head.valid = count_ff != '0;
   assign head.item  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

@@ hdl/owbm_engine.sv @@
// Bus engine: timing registers, slot sequencer and result register.
// Takes one queue item per cycle unless a result stalls. Depends on owbm_pkg.
`default_nettype none

module owbm_engine #(
   parameter int COUNT_WIDTH = owbm_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wr_en,
   input  wire logic [owbm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [owbm_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  wire owbm_pkg::queue_out_type             head,
   output logic                                     pop,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_drive_low,
   output logic                                     rsp_busy_res,
   output logic                                     rsp_done_res,
   output logic                                     rsp_presence,
   output logic [7:0]                               rsp_rx_byte,
   output logic                                     rsp_rejected
);

   localparam int CMP_WIDTH =
      ((COUNT_WIDTH > owbm_pkg::LEN_WIDTH) ? COUNT_WIDTH : owbm_pkg::LEN_WIDTH) + 1;

   // timing registers
   logic [9:0] reset_low_ff, reset_recover_ff;
   logic [7:0] presence_wait_ff, write_hold_ff, read_sample_ff, read_tail_ff;
   logic [5:0] slot_low_ff;

   // sequencer state
   owbm_pkg::phase_type    phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] tick_ff, tick_in;
   logic [2:0]             bit_ff, bit_in;
   logic [7:0]             shift_ff, shift_in;
   logic                   pres_ff, pres_in;
   logic [7:0]             rxb_ff, rxb_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       drive_ff, busy_ff, done_ff, rej_ff;
   logic       drive_new, busy_new, done_now, rej_now;

   logic [owbm_pkg::LEN_WIDTH-1:0] len_sel, len_eff;
   logic                           busy, phase_end;
   owbm_pkg::item_type             item;

   assign item = head.item;
   assign busy = phase_ff != owbm_pkg::PH_IDLE;
   assign pop  = head.valid && (!rsp_valid_ff || !rsp_stall);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         reset_low_ff     <= owbm_pkg::RESET_LOW_DEFAULT;
         presence_wait_ff <= owbm_pkg::PRESENCE_WAIT_DEFAULT;
         reset_recover_ff <= owbm_pkg::RESET_RECOVER_DEFAULT;
         slot_low_ff      <= owbm_pkg::SLOT_LOW_DEFAULT;
         write_hold_ff    <= owbm_pkg::WRITE_HOLD_DEFAULT;
         read_sample_ff   <= owbm_pkg::READ_SAMPLE_DEFAULT;
         read_tail_ff     <= owbm_pkg::READ_TAIL_DEFAULT;
      end else if (csr_wr_en) begin
         case (csr_index)
            owbm_pkg::CSR_RESET_LOW:     reset_low_ff     <= csr_wdata[9:0];
            owbm_pkg::CSR_PRESENCE_WAIT: presence_wait_ff <= csr_wdata[7:0];
            owbm_pkg::CSR_RESET_RECOVER: reset_recover_ff <= csr_wdata[9:0];
            owbm_pkg::CSR_SLOT_LOW:      slot_low_ff      <= csr_wdata[5:0];
            owbm_pkg::CSR_WRITE_HOLD:    write_hold_ff    <= csr_wdata[7:0];
            owbm_pkg::CSR_READ_SAMPLE:   read_sample_ff   <= csr_wdata[7:0];
            owbm_pkg::CSR_READ_TAIL:     read_tail_ff     <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // duration of the current phase; zero counts as one tick
   always_comb begin
      case (phase_ff)
         owbm_pkg::PH_RST_LOW:     len_sel = reset_low_ff;
         owbm_pkg::PH_RST_WAIT:    len_sel = owbm_pkg::LEN_WIDTH'(presence_wait_ff);
         owbm_pkg::PH_RST_RECOVER: len_sel = reset_recover_ff;
         owbm_pkg::PH_WR_LOW:      len_sel = owbm_pkg::LEN_WIDTH'(slot_low_ff);
         owbm_pkg::PH_WR_HOLD:     len_sel = owbm_pkg::LEN_WIDTH'(write_hold_ff);
         owbm_pkg::PH_RD_LOW:      len_sel = owbm_pkg::LEN_WIDTH'(slot_low_ff);
         owbm_pkg::PH_RD_WAIT:     len_sel = owbm_pkg::LEN_WIDTH'(read_sample_ff);
         owbm_pkg::PH_RD_TAIL:     len_sel = owbm_pkg::LEN_WIDTH'(read_tail_ff);
         default:                  len_sel = owbm_pkg::LEN_WIDTH'(1);
      endcase
      len_eff   = (len_sel == '0) ? owbm_pkg::LEN_WIDTH'(1) : len_sel;
      phase_end = (CMP_WIDTH'(tick_ff) + CMP_WIDTH'(1) >= CMP_WIDTH'(len_eff))
                  || (&tick_ff);
   end

   // next state
   always_comb begin
      phase_in = phase_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      pres_in  = pres_ff;
      rxb_in   = rxb_ff;
      done_now = 1'b0;
      rej_now  = 1'b0;
      if (pop) begin
         if (item.kind == owbm_pkg::ITEM_TICK) begin
            if (busy && !phase_end) begin
               tick_in = tick_ff + 1'b1;
            end else if (busy) begin
               tick_in = '0;
               case (phase_ff)
                  owbm_pkg::PH_RST_LOW: begin
                     phase_in = owbm_pkg::PH_RST_WAIT;
                  end
                  owbm_pkg::PH_RST_WAIT: begin
                     pres_in  = !item.line_in;
                     phase_in = owbm_pkg::PH_RST_RECOVER;
                  end
                  owbm_pkg::PH_RST_RECOVER: begin
                     phase_in = owbm_pkg::PH_IDLE;
                     done_now = 1'b1;
                  end
                  owbm_pkg::PH_WR_LOW: begin
                     phase_in = owbm_pkg::PH_WR_HOLD;
                  end
                  owbm_pkg::PH_RD_LOW: begin
                     phase_in = owbm_pkg::PH_RD_WAIT;
                  end
                  owbm_pkg::PH_RD_WAIT: begin
                     shift_in = shift_ff | (8'(item.line_in) << bit_ff);
                     phase_in = owbm_pkg::PH_RD_TAIL;
                  end
                  owbm_pkg::PH_WR_HOLD, owbm_pkg::PH_RD_TAIL: begin
                     if (&bit_ff) begin
                        if (phase_ff == owbm_pkg::PH_RD_TAIL) begin
                           rxb_in = shift_ff;
                        end
                        phase_in = owbm_pkg::PH_IDLE;
                        bit_in   = '0;
                        done_now = 1'b1;
                     end else begin
                        bit_in   = bit_ff + 1'b1;
                        phase_in = (phase_ff == owbm_pkg::PH_WR_HOLD) ?
                                   owbm_pkg::PH_WR_LOW : owbm_pkg::PH_RD_LOW;
                     end
                  end
                  default: begin
                     phase_in = owbm_pkg::PH_IDLE;
                  end
               endcase
            end
         end else if (busy) begin
            // command while busy: dropped
            rej_now = 1'b1;
         end else begin
            tick_in = '0;
            bit_in  = '0;
            if (item.kind == owbm_pkg::ITEM_RESET) begin
               phase_in = owbm_pkg::PH_RST_LOW;
            end else if (item.kind == owbm_pkg::ITEM_WRITE) begin
               shift_in = item.tx_byte;
               phase_in = owbm_pkg::PH_WR_LOW;
            end else begin
               shift_in = '0;
               phase_in = owbm_pkg::PH_RD_LOW;
            end
         end
      end
   end

   // bus drive and busy as of the new state
   always_comb begin
      case (phase_in)
         owbm_pkg::PH_RST_LOW, owbm_pkg::PH_WR_LOW, owbm_pkg::PH_RD_LOW: begin
            drive_new = 1'b1;
         end
         owbm_pkg::PH_WR_HOLD: begin
            drive_new = !shift_in[bit_in];
         end
         default: begin
            drive_new = 1'b0;
         end
      endcase
      busy_new = phase_in != owbm_pkg::PH_IDLE;
   end

   always_comb begin
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= owbm_pkg::PH_IDLE;
         tick_ff      <= '0;
         bit_ff       <= '0;
         shift_ff     <= '0;
         pres_ff      <= 1'b0;
         rxb_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         bit_ff       <= bit_in;
         shift_ff     <= shift_in;
         pres_ff      <= pres_in;
         rxb_ff       <= rxb_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         drive_ff <= drive_new;
         busy_ff  <= busy_new;
         done_ff  <= done_now;
         rej_ff   <= rej_now;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive_low = drive_ff;
   assign rsp_busy_res  = busy_ff;
   assign rsp_done_res  = done_ff;
   assign rsp_rejected  = rej_ff;
   // presence and read byte registers change only with a popped item
   assign rsp_presence  = pres_ff;
   assign rsp_rx_byte   = rxb_ff;

endmodule

`default_nettype wire

@@ hdl/one_wire_bus_master.sv @@
// Top level of the one-wire bus master: front stage, item queue, bus engine.
// Depends on owbm_pkg, owbm_front, owbm_queue and owbm_engine.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  op, tx_byte, line_in
//   rsp_      out        rsp_valid/rsp_stall  drive_low, busy_res, done_res,
//                                             presence, rx_byte, rejected
//   csr_      in         csr_wr_en            csr_index, csr_wdata
//
// One item per clock sustained while the result channel does not stall; each
// item's result passes the front register, queue and result register in turn.
// The front register and two-entry queue absorb a stalled result channel.
// Synchronous reset empties the pipeline, sets the engine idle and loads
// the default timing registers.

`default_nettype none

module one_wire_bus_master #(
   parameter int COUNT_WIDTH = owbm_pkg::COUNT_WIDTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [1:0]                          req_op,
   input  wire logic [7:0]                          req_tx_byte,
   input  wire logic                                req_line_in,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic                                     rsp_drive_low,
   output logic                                     rsp_busy_res,
   output logic                                     rsp_done_res,
   output logic                                     rsp_presence,
   output logic [7:0]                               rsp_rx_byte,
   output logic                                     rsp_rejected,
   input  wire logic                                csr_wr_en,
   input  wire logic [owbm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [owbm_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic                     q_ready, q_push, q_pop;
   owbm_pkg::item_type       q_item;
   owbm_pkg::queue_out_type  q_head;

   owbm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_op      (req_op),
      .req_tx_byte (req_tx_byte),
      .req_line_in (req_line_in),
      .q_ready     (q_ready),
      .q_push      (q_push),
      .q_item      (q_item)
   );

   owbm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .ready     (q_ready),
      .pop       (q_pop),
      .head      (q_head)
   );

   owbm_engine #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .head          (q_head),
      .pop           (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_drive_low (rsp_drive_low),
      .rsp_busy_res  (rsp_busy_res),
      .rsp_done_res  (rsp_done_res),
      .rsp_presence  (rsp_presence),
      .rsp_rx_byte   (rsp_rx_byte),
      .rsp_rejected  (rsp_rejected)
   );

endmodule

`default_nettype wire

@@ hdl/owbm_checker.sv @@
// Port-level checks for the one-wire bus master, bound to the top level.
// Depends on one_wire_bus_master's port names only.
`default_nettype none

module owbm_port_checks (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_drive_low,
   input wire logic       rsp_busy_res,
   input wire logic       rsp_done_res,
   input wire logic       rsp_rejected,
   input wire logic [7:0] rsp_rx_byte
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_rx_byte))
      else $error("stalled result changed");

   // nothing comes out the cycle after reset is released
   assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result straight after reset");

   // a finished operation leaves the engine idle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res && !rsp_rejected)
      else $error("done while busy");

   // only a busy engine drops commands
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rejected |-> rsp_busy_res)
      else $error("rejected while idle");

   // the bus is only pulled low during an operation
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_drive_low |-> rsp_busy_res)
      else $error("bus driven while idle");

endmodule

bind one_wire_bus_master owbm_port_checks u_owbm_checker (.*);

`default_nettype wire

@@ verif/owbm_checker.sv @@
// Checker for the one-wire bus master: watches the item, result and register ports,
// predicts each result from its own copy of the bus engine and compares field by field.
// Depends on owbm_pkg for op codes, register indexes, defaults and the phase enum.
`timescale 1ns / 1ps

module owbm_checker #(
   parameter int COUNT_WIDTH = owbm_pkg::COUNT_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [1:0]                          req_op,
   input  logic [7:0]                          req_tx_byte,
   input  logic                                req_line_in,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic                                rsp_drive_low,
   input  logic                                rsp_busy_res,
   input  logic                                rsp_done_res,
   input  logic                                rsp_presence,
   input  logic [7:0]                          rsp_rx_byte,
   input  logic                                rsp_rejected,
   input  logic                                csr_wr_en,
   input  logic [owbm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [owbm_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata,
   output int                                  error_count,
   output int                                  results_pending
);

   localparam int COUNT_MAX = (1 << COUNT_WIDTH) - 1;

   typedef struct packed {
      logic       drive_low;
      logic       busy;
      logic       done;
      logic       presence;
      logic [7:0] rx_byte;
      logic       rejected;
   } bus_result_type;

   // timing registers, as the block holds them
   logic [9:0] cfg_reset_low;
   logic [7:0] cfg_presence_wait;
   logic [9:0] cfg_reset_recover;
   logic [5:0] cfg_slot_low;
   logic [7:0] cfg_write_hold;
   logic [7:0] cfg_read_sample;
   logic [7:0] cfg_read_tail;

   // engine state
   owbm_pkg::phase_type bus_phase;
   int                  tick_cnt;
   logic [2:0]          bit_idx;
   logic [7:0]          shift_reg;
   logic                presence_seen;
   logic [7:0]          rx_last;

   bus_result_type results_due [$];

   function automatic int phase_ticks(owbm_pkg::phase_type p);
      case (p)
         owbm_pkg::PH_RST_LOW:     return int'(cfg_reset_low);
         owbm_pkg::PH_RST_WAIT:    return int'(cfg_presence_wait);
         owbm_pkg::PH_RST_RECOVER: return int'(cfg_reset_recover);
         owbm_pkg::PH_WR_LOW:      return int'(cfg_slot_low);
         owbm_pkg::PH_WR_HOLD:     return int'(cfg_write_hold);
         owbm_pkg::PH_RD_LOW:      return int'(cfg_slot_low);
         owbm_pkg::PH_RD_WAIT:     return int'(cfg_read_sample);
         owbm_pkg::PH_RD_TAIL:     return int'(cfg_read_tail);
         default:                  return 1;
      endcase
   endfunction

   function automatic logic engine_busy();
      return (bus_phase >= owbm_pkg::PH_RST_LOW) && (bus_phase <= owbm_pkg::PH_RD_TAIL);
   endfunction

   function automatic logic pulls_low();
      case (bus_phase)
         owbm_pkg::PH_RST_LOW, owbm_pkg::PH_WR_LOW, owbm_pkg::PH_RD_LOW: return 1'b1;
         owbm_pkg::PH_WR_HOLD: return !shift_reg[bit_idx];
         default:              return 1'b0;
      endcase
   endfunction

   // one microsecond tick; returns 1 when the operation completes
   function automatic logic advance_tick(logic line);
      int   len;
      logic fin;
      len = phase_ticks(bus_phase);
      fin = 1'b0;
      if (len == 0) len = 1;
      if ((tick_cnt + 1 < len) && (tick_cnt < COUNT_MAX)) begin
         tick_cnt = tick_cnt + 1;
         return 1'b0;
      end
      tick_cnt = 0;
      case (bus_phase)
         owbm_pkg::PH_RST_LOW: bus_phase = owbm_pkg::PH_RST_WAIT;
         owbm_pkg::PH_RST_WAIT: begin
            presence_seen = !line;
            bus_phase = owbm_pkg::PH_RST_RECOVER;
         end
         owbm_pkg::PH_RST_RECOVER: begin
            bus_phase = owbm_pkg::PH_IDLE;
            fin = 1'b1;
         end
         owbm_pkg::PH_WR_LOW: bus_phase = owbm_pkg::PH_WR_HOLD;
         owbm_pkg::PH_WR_HOLD, owbm_pkg::PH_RD_TAIL: begin
            if (bit_idx == 3'd7) begin
               if (bus_phase == owbm_pkg::PH_RD_TAIL) rx_last = shift_reg;
               bus_phase = owbm_pkg::PH_IDLE;
               bit_idx = 3'd0;
               fin = 1'b1;
            end else begin
               bit_idx = bit_idx + 3'd1;
               bus_phase = (bus_phase == owbm_pkg::PH_WR_HOLD) ?
                           owbm_pkg::PH_WR_LOW : owbm_pkg::PH_RD_LOW;
            end
         end
         owbm_pkg::PH_RD_LOW: bus_phase = owbm_pkg::PH_RD_WAIT;
         owbm_pkg::PH_RD_WAIT: begin
            if (line) shift_reg[bit_idx] = 1'b1;
            bus_phase = owbm_pkg::PH_RD_TAIL;
         end
         default: bus_phase = owbm_pkg::PH_IDLE;
      endcase
      return fin;
   endfunction

   // result that one accepted item should give
   function automatic bus_result_type predict_bus_result(logic [1:0] op, logic [7:0] tx,
                                                         logic line);
      bus_result_type r;
      r = '0;
      if (op == owbm_pkg::OP_TICK) begin
         if (engine_busy()) r.done = advance_tick(line);
      end else if (engine_busy()) begin
         r.rejected = 1'b1;
      end else begin
         tick_cnt = 0;
         bit_idx = 3'd0;
         case (op)
            owbm_pkg::OP_RESET: bus_phase = owbm_pkg::PH_RST_LOW;
            owbm_pkg::OP_WRITE: begin
               shift_reg = tx;
               bus_phase = owbm_pkg::PH_WR_LOW;
            end
            default: begin
               shift_reg = 8'h00;
               bus_phase = owbm_pkg::PH_RD_LOW;
            end
         endcase
      end
      r.drive_low = pulls_low();
      r.busy      = engine_busy();
      r.presence  = presence_seen;
      r.rx_byte   = rx_last;
      return r;
   endfunction

   function automatic int field_mismatch(string name, logic [7:0] due, logic [7:0] seen);
      if (due === seen) return 0;
      $error("%s expected %0d got %0d", name, due, seen);
      return 1;
   endfunction

   always @(posedge clock) begin : watch_channels
      bus_result_type due;
      int             errs;
      errs = 0;
      if (reset) begin
         cfg_reset_low     = owbm_pkg::RESET_LOW_DEFAULT;
         cfg_presence_wait = owbm_pkg::PRESENCE_WAIT_DEFAULT;
         cfg_reset_recover = owbm_pkg::RESET_RECOVER_DEFAULT;
         cfg_slot_low      = owbm_pkg::SLOT_LOW_DEFAULT;
         cfg_write_hold    = owbm_pkg::WRITE_HOLD_DEFAULT;
         cfg_read_sample   = owbm_pkg::READ_SAMPLE_DEFAULT;
         cfg_read_tail     = owbm_pkg::READ_TAIL_DEFAULT;
         bus_phase     = owbm_pkg::PH_IDLE;
         tick_cnt      = 0;
         bit_idx       = 3'd0;
         shift_reg     = 8'h00;
         presence_seen = 1'b0;
         rx_last       = 8'h00;
         results_due.delete();
      end else begin
         // register writes, masked to each register's width
         if (csr_wr_en) begin
            case (csr_index)
               owbm_pkg::CSR_RESET_LOW:     cfg_reset_low     = csr_wdata[9:0];
               owbm_pkg::CSR_PRESENCE_WAIT: cfg_presence_wait = csr_wdata[7:0];
               owbm_pkg::CSR_RESET_RECOVER: cfg_reset_recover = csr_wdata[9:0];
               owbm_pkg::CSR_SLOT_LOW:      cfg_slot_low      = csr_wdata[5:0];
               owbm_pkg::CSR_WRITE_HOLD:    cfg_write_hold    = csr_wdata[7:0];
               owbm_pkg::CSR_READ_SAMPLE:   cfg_read_sample   = csr_wdata[7:0];
               owbm_pkg::CSR_READ_TAIL:     cfg_read_tail     = csr_wdata[7:0];
               default: ;
            endcase
         end
         // compare a delivered result with the oldest one due
         if (rsp_valid && !rsp_stall) begin
            if (results_due.size() == 0) begin
               $error("result item arrived with none due");
               errs++;
            end else begin
               due = results_due.pop_front();
               errs += field_mismatch("drive_low", due.drive_low, rsp_drive_low);
               errs += field_mismatch("busy_res", due.busy, rsp_busy_res);
               errs += field_mismatch("done_res", due.done, rsp_done_res);
               errs += field_mismatch("presence", due.presence, rsp_presence);
               errs += field_mismatch("rx_byte", due.rx_byte, rsp_rx_byte);
               errs += field_mismatch("rejected", due.rejected, rsp_rejected);
            end
         end
         if (req_valid && !req_stall)
            results_due.push_back(predict_bus_result(req_op, req_tx_byte, req_line_in));
      end
      error_count     <= error_count + errs;
      results_pending <= results_due.size();
   end

endmodule

@@ verif/tb_one_wire_bus_master.sv @@
// Testbench top for the one-wire bus master: clock, reset, item and register stimulus.
// Depends on owbm_pkg, the block one_wire_bus_master and the checker owbm_checker.
`timescale 1ns / 1ps

module tb_one_wire_bus_master;

   localparam int COUNT_WIDTH      = owbm_pkg::COUNT_WIDTH_DEFAULT;
   localparam int LONG_HOLD        = 200;
   localparam int WATCHDOG_LIMIT   = 3000;
   localparam int DRAIN_ROUNDS_MAX = 1000;
   localparam int PHASE_ITEMS      = 180;
   localparam int MAX_STAGE_TICKS  = 330;
   localparam logic [owbm_pkg::CSR_INDEX_WIDTH-1:0] CSR_SPARE = 3'd7;

   typedef enum int {LINE_LOW, LINE_HIGH, LINE_RANDOM} line_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_op = owbm_pkg::OP_TICK;
   logic [7:0] req_tx_byte = 8'h00;
   logic       req_line_in = 1'b1;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_drive_low;
   logic       rsp_busy_res;
   logic       rsp_done_res;
   logic       rsp_presence;
   logic [7:0] rsp_rx_byte;
   logic       rsp_rejected;
   logic       csr_wr_en = 1'b0;
   logic [owbm_pkg::CSR_INDEX_WIDTH-1:0] csr_index = owbm_pkg::CSR_RESET_LOW;
   logic [owbm_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   int   error_count;
   int   results_pending;
   int   items_sent;
   int   idle_cycles;
   int   hold_requests;
   int   holds_served;
   bit   gaps_on = 1'b1;
   logic last_busy = 1'b0;

   // timing values as last programmed, masked to register width
   logic [9:0] timing [7];

   always #4 clock = ~clock;

   one_wire_bus_master #(.COUNT_WIDTH(COUNT_WIDTH)) u_top (.*);

   owbm_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_checker (.*);

   // busy flag of the latest delivered result
   always @(posedge clock)
      if (rsp_valid && !rsp_stall) last_busy <= rsp_busy_res;

   // watchdog on cycles with no traffic at all
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // result sink: random stall after each item, one long hold on request
   initial begin : rsp_sink
      int hold;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (holds_served != hold_requests) begin
               hold = LONG_HOLD;
               holds_served++;
            end else
               hold = gaps_on ? $urandom_range(0, 10) : 0;
            if (hold > 0) begin
               rsp_stall <= 1'b1;
               repeat (hold) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   function automatic logic [9:0] reg_mask(int idx);
      case (idx)
         owbm_pkg::CSR_RESET_LOW, owbm_pkg::CSR_RESET_RECOVER: return 10'h3FF;
         owbm_pkg::CSR_SLOT_LOW:                               return 10'h03F;
         default:                                              return 10'h0FF;
      endcase
   endfunction

   // ticks an operation needs to complete under the current timing
   function automatic int op_ticks(logic [1:0] op);
      int d [7];
      foreach (d[i]) d[i] = (timing[i] == 0) ? 1 : int'(timing[i]);
      case (op)
         owbm_pkg::OP_RESET:
            return d[owbm_pkg::CSR_RESET_LOW] + d[owbm_pkg::CSR_PRESENCE_WAIT] +
                   d[owbm_pkg::CSR_RESET_RECOVER];
         owbm_pkg::OP_WRITE:
            return 8 * (d[owbm_pkg::CSR_SLOT_LOW] + d[owbm_pkg::CSR_WRITE_HOLD]);
         default:
            return 8 * (d[owbm_pkg::CSR_SLOT_LOW] + d[owbm_pkg::CSR_READ_SAMPLE] +
                        d[owbm_pkg::CSR_READ_TAIL]);
      endcase
   endfunction

   function automatic logic pick_line(line_mode_type mode);
      case (mode)
         LINE_LOW:  return 1'b0;
         LINE_HIGH: return 1'b1;
         default:   return 1'($urandom_range(0, 1));
      endcase
   endfunction

   // offer one item after a random gap and wait until it is taken
   task automatic send_item(input logic [1:0] op, input logic [7:0] tx, input logic line);
      int gap;
      gap = gaps_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_op      <= op;
      req_tx_byte <= tx;
      req_line_in <= line;
      do @(posedge clock); while (req_stall);
      items_sent++;
   endtask

   task automatic wait_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_pending != 0);
   endtask

   // stop offering, then tick until the engine reports idle
   task automatic drain_bus();
      int rounds;
      rounds = 0;
      wait_results();
      while (last_busy) begin
         if (rounds >= DRAIN_ROUNDS_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
         rounds++;
         repeat (8) send_item(owbm_pkg::OP_TICK, 8'($urandom), 1'($urandom));
         wait_results();
      end
   endtask

   // write all timing registers, junk in unused upper bits, plus the spare index
   task automatic program_timing();
      for (int i = int'(owbm_pkg::CSR_RESET_LOW); i <= int'(CSR_SPARE); i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= owbm_pkg::CSR_INDEX_WIDTH'(i);
         if (i == int'(CSR_SPARE))
            csr_wdata <= owbm_pkg::CSR_DATA_WIDTH'($urandom);
         else
            csr_wdata <= owbm_pkg::CSR_DATA_WIDTH'(timing[i] |
                                                   ($urandom & ~32'(reg_mask(i))));
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   // command then its ticks; a noisy run may be cut short or carry stray commands
   task automatic run_op(input logic [1:0] op, input logic [7:0] tx,
                         input line_mode_type mode, input bit noisy);
      int n;
      n = op_ticks(op);
      if (noisy && $urandom_range(0, 9) == 0) n = $urandom_range(0, n);
      send_item(op, tx, pick_line(mode));
      repeat (n) begin
         if (noisy && $urandom_range(0, 29) == 0)
            send_item(2'($urandom_range(owbm_pkg::OP_RESET, owbm_pkg::OP_READ)),
                      8'($urandom), 1'($urandom));
         send_item(owbm_pkg::OP_TICK, 8'($urandom), pick_line(mode));
      end
      if (noisy)
         repeat ($urandom_range(0, 2))
            send_item(owbm_pkg::OP_TICK, 8'($urandom), 1'($urandom));
   endtask

   initial begin : stimulus
      int target;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset values of the timing registers; one full write byte at them
      timing[owbm_pkg::CSR_RESET_LOW]     = owbm_pkg::RESET_LOW_DEFAULT;
      timing[owbm_pkg::CSR_PRESENCE_WAIT] = 10'(owbm_pkg::PRESENCE_WAIT_DEFAULT);
      timing[owbm_pkg::CSR_RESET_RECOVER] = owbm_pkg::RESET_RECOVER_DEFAULT;
      timing[owbm_pkg::CSR_SLOT_LOW]      = 10'(owbm_pkg::SLOT_LOW_DEFAULT);
      timing[owbm_pkg::CSR_WRITE_HOLD]    = 10'(owbm_pkg::WRITE_HOLD_DEFAULT);
      timing[owbm_pkg::CSR_READ_SAMPLE]   = 10'(owbm_pkg::READ_SAMPLE_DEFAULT);
      timing[owbm_pkg::CSR_READ_TAIL]     = 10'(owbm_pkg::READ_TAIL_DEFAULT);
      run_op(owbm_pkg::OP_WRITE, 8'hA5, LINE_RANDOM, 1'b0);
      drain_bus();

      // directed: one-tick phases, idle ticks, rejects, byte extremes
      foreach (timing[i]) timing[i] = 10'd1;
      program_timing();
      send_item(owbm_pkg::OP_TICK, 8'hFF, 1'b0);
      send_item(owbm_pkg::OP_TICK, 8'h00, 1'b1);
      send_item(owbm_pkg::OP_RESET, 8'h00, 1'b1);
      send_item(owbm_pkg::OP_RESET, 8'hFF, 1'b0);
      send_item(owbm_pkg::OP_WRITE, 8'hFF, 1'b1);
      send_item(owbm_pkg::OP_READ, 8'h00, 1'b0);
      repeat (op_ticks(owbm_pkg::OP_RESET)) send_item(owbm_pkg::OP_TICK, 8'h00, 1'b0);
      run_op(owbm_pkg::OP_RESET, 8'h00, LINE_HIGH, 1'b0);
      run_op(owbm_pkg::OP_WRITE, 8'h00, LINE_RANDOM, 1'b0);
      run_op(owbm_pkg::OP_WRITE, 8'hFF, LINE_RANDOM, 1'b0);
      run_op(owbm_pkg::OP_READ, 8'hFF, LINE_HIGH, 1'b0);
      run_op(owbm_pkg::OP_READ, 8'h00, LINE_LOW, 1'b0);
      send_item(owbm_pkg::OP_TICK, 8'h5A, 1'b1);
      drain_bus();

      // zero in every register counts as one tick
      foreach (timing[i]) timing[i] = 10'd0;
      program_timing();
      repeat (20)
         run_op(2'($urandom_range(owbm_pkg::OP_RESET, owbm_pkg::OP_READ)), 8'($urandom),
                LINE_RANDOM, 1'b1);
      drain_bus();

      // random short timings; long result hold in one phase, sender pause in another
      for (int p = 0; p < 4; p++) begin
         foreach (timing[i]) timing[i] = 10'($urandom_range(0, 3));
         program_timing();
         gaps_on = (p != 2);
         target = items_sent + PHASE_ITEMS;
         while (items_sent < target) begin
            if (p == 1 && hold_requests == 0) hold_requests++;
            run_op(2'($urandom_range(owbm_pkg::OP_RESET, owbm_pkg::OP_READ)), 8'($urandom),
                   line_mode_type'($urandom_range(LINE_LOW, LINE_RANDOM)), 1'b1);
            if (p == 3 && items_sent > target - 120 && items_sent < target - 60)
               wait_results();
         end
         drain_bus();
      end

      // every register at its maximum, back to back, through the first write slot
      foreach (timing[i]) timing[i] = reg_mask(i);
      program_timing();
      gaps_on = 1'b0;
      send_item(owbm_pkg::OP_WRITE, 8'($urandom), 1'b1);
      repeat (MAX_STAGE_TICKS) send_item(owbm_pkg::OP_TICK, 8'($urandom), 1'($urandom));
      wait_results();

      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
